// ===== src/decimal_length_prefix_deframer_macros.svh =====
// ============================================================================
// Assertion macros for the decimal length-prefix deframer
// Shared shorthand for the concurrent checks on the block's ports.
// ============================================================================
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define DLPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after the condition.
`define DLPD_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// ===== src/dlpd_pkg.sv =====
// ============================================================================
// dlpd_pkg
// Types and constants shared by the deframer's front end, queue and back end.
// ============================================================================
package dlpd_pkg;

    localparam int DEFAULT_LENGTH_BITS = 24;
    localparam int MAX_LEN_BITS        = 24;
    localparam int CFG_ADDR_BITS       = 3;
    localparam int CFG_DATA_BITS       = 32;

    localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 24'd65535;

    // Register index, taken from the word address.
    localparam logic REG_MAX_MESSAGE_LENGTH = 1'b0;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_SKIP_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_IGNORE,
        PH_BODY,
        PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BODY,
        KIND_LAST,
        KIND_ERROR
    } kind_t;

    // One request from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } request_t;

endpackage

// ===== src/dlpd_front.sv =====
// ============================================================================
// dlpd_front
// Header parser: classifies each stream byte and issues body and error requests.
// ============================================================================
module dlpd_front #(
    parameter int LENGTH_BITS = dlpd_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          stream_byte,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dlpd_pkg::MAX_LEN_BITS-1:0]   max_message_length,
    input  logic                                queue_full,
    output logic                                push,
    output dlpd_pkg::request_t                  push_req
);

    localparam int CMP_BITS = (LENGTH_BITS > dlpd_pkg::MAX_LEN_BITS) ?
                              LENGTH_BITS : dlpd_pkg::MAX_LEN_BITS;

    dlpd_pkg::phase_t       phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;

    logic                   accept;
    logic                   is_blank, is_digit, is_colon;
    logic [LENGTH_BITS+3:0] times_ten;
    logic                   digit_ovf;
    logic                   header_bad;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign is_colon = (stream_byte == dlpd_pkg::CHAR_COLON);
    assign is_blank = (stream_byte == dlpd_pkg::CHAR_SPACE) ||
                      ((stream_byte >= dlpd_pkg::CHAR_TAB) &&
                       (stream_byte <= dlpd_pkg::CHAR_CR));
    assign is_digit = (stream_byte >= dlpd_pkg::CHAR_ZERO) &&
                      (stream_byte <= dlpd_pkg::CHAR_NINE);

    // acc * 10 + digit, built from two shifts; the top four bits flag overflow.
    assign times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                       {{LENGTH_BITS{1'b0}}, stream_byte[3:0]};
    assign digit_ovf = |times_ten[LENGTH_BITS+3:LENGTH_BITS];

    assign header_bad = neg_reg || ovf_reg || (acc_reg == '0) ||
                        (CMP_BITS'(acc_reg) > CMP_BITS'(max_message_length));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dlpd_pkg::PH_SKIP_WS;
            acc_reg   <= '0;
            left_reg  <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        neg_next      = neg_reg;
        ovf_next      = ovf_reg;
        push          = 1'b0;
        push_req.data = stream_byte;
        push_req.kind = dlpd_pkg::KIND_BODY;

        if (accept)
        begin
            unique case (phase_reg) inside
                dlpd_pkg::PH_DEAD:
                begin
                end
                dlpd_pkg::PH_BODY:
                begin
                    push = 1'b1;
                    if (left_reg <= LENGTH_BITS'(1))
                    begin
                        push_req.kind = dlpd_pkg::KIND_LAST;
                        left_next     = '0;
                        phase_next    = dlpd_pkg::PH_SKIP_WS;
                        acc_next      = '0;
                        neg_next      = 1'b0;
                        ovf_next      = 1'b0;
                    end
                    else
                    begin
                        left_next = left_reg - LENGTH_BITS'(1);
                    end
                end
                default:
                begin
                    if (is_colon)
                    begin
                        if (header_bad)
                        begin
                            push          = 1'b1;
                            push_req.data = 8'h00;
                            push_req.kind = dlpd_pkg::KIND_ERROR;
                            phase_next    = dlpd_pkg::PH_DEAD;
                        end
                        else
                        begin
                            left_next  = acc_reg;
                            phase_next = dlpd_pkg::PH_BODY;
                        end
                    end
                    else if ((phase_reg == dlpd_pkg::PH_SKIP_WS) && is_blank)
                    begin
                        phase_next = dlpd_pkg::PH_SKIP_WS;
                    end
                    else if ((phase_reg == dlpd_pkg::PH_SKIP_WS) &&
                             (stream_byte == dlpd_pkg::CHAR_PLUS))
                    begin
                        phase_next = dlpd_pkg::PH_SIGN;
                    end
                    else if ((phase_reg == dlpd_pkg::PH_SKIP_WS) &&
                             (stream_byte == dlpd_pkg::CHAR_MINUS))
                    begin
                        neg_next   = 1'b1;
                        phase_next = dlpd_pkg::PH_SIGN;
                    end
                    else if (is_digit && (phase_reg != dlpd_pkg::PH_IGNORE))
                    begin
                        phase_next = dlpd_pkg::PH_DIGITS;
                        // Once saturated, further digits leave the value alone.
                        if (!ovf_reg)
                        begin
                            if (digit_ovf)
                            begin
                                ovf_next = 1'b1;
                                acc_next = '1;
                            end
                            else
                            begin
                                acc_next = times_ten[LENGTH_BITS-1:0];
                            end
                        end
                    end
                    else
                    begin
                        phase_next = dlpd_pkg::PH_IGNORE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== src/dlpd_queue.sv =====
// ============================================================================
// dlpd_queue
// Two-slot request queue between the front end and the back end.
// ============================================================================
module dlpd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dlpd_pkg::request_t push_req,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output dlpd_pkg::request_t head
);

    logic [1:0]         count_reg, count_next;
    logic [1:0]         kept;
    dlpd_pkg::request_t head_reg, head_next;
    dlpd_pkg::request_t tail_reg, tail_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        // Requests left after this cycle's pop; the tail moves up on a pop.
        kept      = count_reg - {1'b0, pop};
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if (kept == 2'd0)
            begin
                head_next = push_req;
            end
            else
            begin
                tail_next = push_req;
            end
        end
        count_next = kept + {1'b0, push};
    end

endmodule

// ===== src/dlpd_back.sv =====
// ============================================================================
// dlpd_back
// Decodes queued requests into result fields and holds them in the output register.
// ============================================================================
module dlpd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  dlpd_pkg::request_t head,
    output logic               pop,
    output logic [7:0]         body_byte,
    output logic               last_of_message,
    output logic               header_error,
    output logic               out_valid,
    input  logic               out_ready
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    assign pop             = !empty && (!valid_reg || out_ready);
    assign out_valid       = valid_reg;
    assign body_byte       = byte_reg;
    assign last_of_message = last_reg;
    assign header_error    = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            byte_next  = head.data;
            last_next  = 1'b0;
            err_next   = 1'b0;
            unique case (head.kind)
                dlpd_pkg::KIND_BODY:
                begin
                end
                dlpd_pkg::KIND_LAST:
                begin
                    last_next = 1'b1;
                end
                dlpd_pkg::KIND_ERROR:
                begin
                    byte_next = 8'h00;
                    err_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

endmodule

// ===== src/decimal_length_prefix_deframer.sv =====
// ============================================================================
// decimal_length_prefix_deframer
// Splits a byte stream of "<decimal length>:<body>" messages into body bytes.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------------------
//  in        in_valid / in_ready    stream_byte
//  out       out_valid / out_ready  body_byte, last_of_message, header_error
//  cfg       APB write/read         max_message_length at byte address 0
//
//  One stream byte is taken every cycle while the queue has room; a result
//  passes through a queue slot, then the output register, and results leave
//  at one per cycle while out_ready is high. The header parser updates its
//  length with one multiply by ten per digit. A stalled output fills the
//  two-slot queue and then holds in_ready low. Reset clears the parser, the
//  queue and the output valid, and sets max_message_length to 65535. After a
//  header error all input is taken and dropped until reset.
//
module decimal_length_prefix_deframer #(
    parameter int LENGTH_BITS = dlpd_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         stream_byte,
    input  logic                               in_valid,
    output logic                               in_ready,
    output logic [7:0]                         body_byte,
    output logic                               last_of_message,
    output logic                               header_error,
    output logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlpd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [dlpd_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    logic [dlpd_pkg::MAX_LEN_BITS-1:0] max_len_reg, max_len_next;
    logic                              reg_hit;

    logic               push, pop, full, empty;
    dlpd_pkg::request_t push_req, head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == dlpd_pkg::REG_MAX_MESSAGE_LENGTH);
    assign prdata  = reg_hit ? dlpd_pkg::CFG_DATA_BITS'(max_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= dlpd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            max_len_next = pwdata[dlpd_pkg::MAX_LEN_BITS-1:0];
        end
    end

    dlpd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .stream_byte        (stream_byte),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .max_message_length (max_len_reg),
        .queue_full         (full),
        .push               (push),
        .push_req           (push_req)
    );

    dlpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    dlpd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .head            (head),
        .pop             (pop),
        .body_byte       (body_byte),
        .last_of_message (last_of_message),
        .header_error    (header_error),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

endmodule

// ===== src/dlpd_checker.sv =====
// ============================================================================
// dlpd_checker
// Port-level checks on the deframer's results, bound to the top level.
// ============================================================================
`include "decimal_length_prefix_deframer_macros.svh"

module dlpd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         body_byte,
    input  logic                               last_of_message,
    input  logic                               header_error,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0] prdata
);

    logic dead_reg;

    // Set once an error result has been delivered; nothing may follow it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg <= 1'b0;
        end
        else if (out_valid && out_ready && header_error)
        begin
            dead_reg <= 1'b1;
        end
    end

    `DLPD_HOLD(a_out_hold, out_valid && !out_ready, body_byte, "output request changed while stalled")

    `DLPD_ASSERT(a_err_fields, (out_valid && header_error) |-> (body_byte == 8'h00 && !last_of_message), "error request carries body fields")

    `DLPD_ASSERT(a_quiet_after_err, dead_reg |-> !out_valid, "result after a header error")

    `DLPD_ASSERT(a_prdata_width, 1'b1 |-> (prdata[dlpd_pkg::CFG_DATA_BITS-1:dlpd_pkg::MAX_LEN_BITS] == '0), "register read has bits above its width")

endmodule

bind decimal_length_prefix_deframer dlpd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .body_byte       (body_byte),
    .last_of_message (last_of_message),
    .header_error    (header_error),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .prdata          (prdata)
);

// ===== tb/dlpd_stream_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// dlpd_stream_checker
// Watches the stream, result and register ports of the deframer, keeps its
// own copy of the header parser and the length limit, and compares every
// result that leaves the block with the oldest predicted one.
// ============================================================================
module dlpd_stream_checker #(
    parameter int LENGTH_BITS = dlpd_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         stream_byte,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [7:0]                         body_byte,
    input  logic                               last_of_message,
    input  logic                               header_error,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlpd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0] pwdata,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0] prdata,
    input  logic                               pready,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 results_seen
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } body_result_t;

    body_result_t                      expected_results[$];
    dlpd_pkg::phase_t                  phase;
    logic [LENGTH_BITS-1:0]            length_so_far;
    logic                              minus_seen;
    logic                              saturated;
    logic [LENGTH_BITS-1:0]            bytes_left;
    logic [dlpd_pkg::MAX_LEN_BITS-1:0] length_limit;

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dlpd_pkg::CHAR_ZERO && c <= dlpd_pkg::CHAR_NINE;
    endfunction

    function automatic void restart_header();
        phase         = dlpd_pkg::PH_SKIP_WS;
        length_so_far = '0;
        minus_seen    = 1'b0;
        saturated     = 1'b0;
    endfunction

    // Once the value no longer fits, it sticks at all ones.
    function automatic void take_digit(input logic [7:0] c);
        logic [LENGTH_BITS+3:0] grown;
        if (saturated)
            return;
        grown = (LENGTH_BITS+4)'(length_so_far);
        grown = grown * (LENGTH_BITS+4)'(10) + (LENGTH_BITS+4)'(c - dlpd_pkg::CHAR_ZERO);
        if (grown > {4'b0, {LENGTH_BITS{1'b1}}})
        begin
            saturated     = 1'b1;
            length_so_far = '1;
        end
        else
            length_so_far = grown[LENGTH_BITS-1:0];
    endfunction

    // Advances the parser by one stream byte and queues the result it causes.
    function automatic void deframe(input logic [7:0] c);
        body_result_t r;
        if (phase == dlpd_pkg::PH_DEAD)
            return;
        if (phase == dlpd_pkg::PH_BODY)
        begin
            r.data = c;
            r.last = (bytes_left <= 1);
            r.err  = 1'b0;
            expected_results.push_back(r);
            if (r.last)
            begin
                bytes_left = '0;
                restart_header();
            end
            else
                bytes_left = bytes_left - 1'b1;
            return;
        end
        if (c == dlpd_pkg::CHAR_COLON)
        begin
            if (minus_seen || saturated || length_so_far == '0 ||
                length_so_far > length_limit)
            begin
                phase = dlpd_pkg::PH_DEAD;
                r     = '{8'h00, 1'b0, 1'b1};
                expected_results.push_back(r);
            end
            else
            begin
                bytes_left = length_so_far;
                phase      = dlpd_pkg::PH_BODY;
            end
            return;
        end
        case (phase)
            dlpd_pkg::PH_SKIP_WS:
            begin
                if (c == dlpd_pkg::CHAR_SPACE ||
                    (c >= dlpd_pkg::CHAR_TAB && c <= dlpd_pkg::CHAR_CR))
                    phase = dlpd_pkg::PH_SKIP_WS;
                else if (c == dlpd_pkg::CHAR_PLUS)
                    phase = dlpd_pkg::PH_SIGN;
                else if (c == dlpd_pkg::CHAR_MINUS)
                begin
                    minus_seen = 1'b1;
                    phase      = dlpd_pkg::PH_SIGN;
                end
                else if (is_digit(c))
                begin
                    take_digit(c);
                    phase = dlpd_pkg::PH_DIGITS;
                end
                else
                    phase = dlpd_pkg::PH_IGNORE;
            end
            dlpd_pkg::PH_SIGN, dlpd_pkg::PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    take_digit(c);
                    phase = dlpd_pkg::PH_DIGITS;
                end
                else
                    phase = dlpd_pkg::PH_IGNORE;
            end
            default:
                phase = dlpd_pkg::PH_IGNORE;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        body_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            restart_header();
            bytes_left   = '0;
            length_limit = dlpd_pkg::MAX_LEN_RESET;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, got byte %02h last %b error %b",
                             $time, body_byte, last_of_message, header_error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (body_byte !== want.data)
                        note_mismatch("body_byte", 32'(want.data), 32'(body_byte));
                    if (last_of_message !== want.last)
                        note_mismatch("last_of_message", 32'(want.last),
                                      32'(last_of_message));
                    if (header_error !== want.err)
                        note_mismatch("header_error", 32'(want.err), 32'(header_error));
                end
            end

            if (in_valid && in_ready)
                deframe(stream_byte);

            // Writes to any other index are ignored by the block.
            if (psel && penable && pready &&
                paddr[dlpd_pkg::CFG_ADDR_BITS-1:2] == dlpd_pkg::REG_MAX_MESSAGE_LENGTH)
            begin
                if (pwrite)
                    length_limit = pwdata[dlpd_pkg::MAX_LEN_BITS-1:0];
                else if (prdata !== dlpd_pkg::CFG_DATA_BITS'(length_limit))
                    note_mismatch("max_message_length read",
                                  dlpd_pkg::CFG_DATA_BITS'(length_limit), prdata);
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_decimal_length_prefix_deframer.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_decimal_length_prefix_deframer
// Drives framed byte streams into the deframer under several length limits,
// with bursty input and a stalling output, and ends the stream with one
// header error followed by bytes that must be dropped.
// ============================================================================
module tb_decimal_length_prefix_deframer;

    localparam int LEN_BITS   = dlpd_pkg::DEFAULT_LENGTH_BITS;
    localparam int HOLD_SPAN  = 80;
    localparam int DROP_COUNT = 16;

    localparam logic [dlpd_pkg::CFG_ADDR_BITS-1:0] ADDR_MAX_MSG_LEN =
        dlpd_pkg::CFG_ADDR_BITS'(4 * dlpd_pkg::REG_MAX_MESSAGE_LENGTH);
    localparam logic [dlpd_pkg::CFG_ADDR_BITS-1:0] ADDR_UNMAPPED =
        dlpd_pkg::CFG_ADDR_BITS'(4);

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_TOGGLE
    } ready_pattern_t;

    typedef enum {
        FAULT_COLON_FIRST,
        FAULT_SIGN_ONLY,
        FAULT_JUNK_FIRST,
        FAULT_NEGATIVE,
        FAULT_MINUS_ZERO,
        FAULT_ZERO_LENGTH,
        FAULT_OVERFLOW,
        FAULT_ABOVE_LIMIT,
        FAULT_LIMIT_ZERO
    } header_fault_t;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic [7:0]                         stream_byte = '0;
    logic                               in_valid    = 1'b0;
    logic                               out_ready   = 1'b0;
    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [dlpd_pkg::CFG_ADDR_BITS-1:0] paddr       = '0;
    logic [dlpd_pkg::CFG_DATA_BITS-1:0] pwdata      = '0;
    logic                               in_ready;
    logic [7:0]                         body_byte;
    logic                               last_of_message;
    logic                               header_error;
    logic                               out_valid;
    logic [dlpd_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          hold_requests  = 0;
    int          burst_left     = 10;
    int          bytes_sent     = 0;
    int          frames_sent    = 0;
    int          settings_used  = 0;
    int unsigned cur_limit      = dlpd_pkg::MAX_LEN_RESET;
    logic [7:0]  header_bytes[$];

    always #1 clk = ~clk;

    decimal_length_prefix_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
        .clk, .rst_n, .stream_byte, .in_valid, .in_ready,
        .body_byte, .last_of_message, .header_error, .out_valid, .out_ready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    dlpd_stream_checker #(.LENGTH_BITS(LEN_BITS)) u_checker (
        .clk, .rst_n, .stream_byte, .in_valid, .in_ready,
        .body_byte, .last_of_message, .header_error, .out_valid, .out_ready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .mismatches(fail_count), .outstanding(pending), .results_seen(results_checked)
    );

    // Offers one stream byte and returns once the request is taken. Bursts of
    // random length are separated by random gaps.
    task automatic push_byte(input logic [7:0] b);
        stream_byte <= b;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Stops offering and waits until every predicted result has left the
    // block, then waits on for anything still in its pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
    endtask

    task automatic apb_transfer(input logic is_write,
                                input logic [dlpd_pkg::CFG_ADDR_BITS-1:0] addr,
                                input logic [dlpd_pkg::CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The upper data bits are random; only the low 24 bits are kept.
    task automatic set_limit(input logic [dlpd_pkg::MAX_LEN_BITS-1:0] value);
        apb_transfer(1'b1, ADDR_MAX_MSG_LEN, {8'($urandom), value});
        apb_transfer(1'b0, ADDR_MAX_MSG_LEN, '0);
        cur_limit = 32'(value);
        settings_used++;
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0:       return dlpd_pkg::CHAR_SPACE;
            1:       return dlpd_pkg::CHAR_TAB;
            2:       return CHAR_LF;
            3:       return CHAR_VT;
            4:       return CHAR_FF;
            default: return dlpd_pkg::CHAR_CR;
        endcase
    endfunction

    // A random header byte that is never a colon, and never a digit unless
    // digits_ok is set.
    function automatic logic [7:0] junk_byte(input bit digits_ok);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == dlpd_pkg::CHAR_COLON ||
               (!digits_ok && b >= dlpd_pkg::CHAR_ZERO && b <= dlpd_pkg::CHAR_NINE));
        return b;
    endfunction

    function automatic void add_decimal(input longint unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++)
            header_bytes.push_back(s[i]);
    endfunction

    task automatic push_frame_head();
        header_bytes.push_back(dlpd_pkg::CHAR_COLON);
        foreach (header_bytes[i])
            push_byte(header_bytes[i]);
        header_bytes.delete();
        frames_sent++;
    endtask

    // One well-formed message with a random header shape and random body.
    task automatic send_message();
        int unsigned len;
        int unsigned roll;
        int unsigned tail;
        roll = $urandom_range(0, 19);
        if (roll < 14)
            len = $urandom_range(1, 6);
        else if (roll < 19)
            len = $urandom_range(7, 24);
        else
            len = $urandom_range(25, 64);
        if (len > cur_limit || (roll == 13 && cur_limit <= 64))
            len = cur_limit;

        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                header_bytes.push_back(blank_byte());
        if ($urandom_range(0, 3) == 0)
            header_bytes.push_back(dlpd_pkg::CHAR_PLUS);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10))
                header_bytes.push_back(dlpd_pkg::CHAR_ZERO);
        add_decimal(len);

        // Text after the digits is ignored up to the colon; a NUL ends the number.
        tail = $urandom_range(0, 5);
        if (tail == 0)
            header_bytes.push_back(CHAR_NUL);
        else if (tail == 1)
            header_bytes.push_back(junk_byte(1'b0));
        if (tail <= 1)
            repeat ($urandom_range(0, 3))
                header_bytes.push_back(junk_byte(1'b1));

        push_frame_head();
        repeat (len)
            push_byte(8'($urandom));
    endtask

    // Output side: a changing ready pattern, and a long hold-off on request.
    initial
    begin
        ready_pattern_t pattern;
        int             pattern_left;
        int             hold_left;
        int             holds_served;
        pattern      = READY_ALWAYS;
        pattern_left = 0;
        hold_left    = 0;
        holds_served = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_SPAN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = ready_pattern_t'($urandom_range(0, READY_TOGGLE));
                    pattern_left = $urandom_range(20, 150);
                end
                pattern_left--;
                case (pattern)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ~out_ready;
                endcase
            end
        end
    end

    initial
    begin
        int unsigned                       phase_limits[5];
        int                                p;
        int                                target;
        header_fault_t                     fault;
        logic [dlpd_pkg::MAX_LEN_BITS-1:0] lim;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the limit.
        apb_transfer(1'b0, ADDR_MAX_MSG_LEN, '0);

        // Shortest legal message with an all-zeros body byte.
        add_decimal(1);
        push_frame_head();
        push_byte(8'h00);

        // Blanks and a plus sign; the body carries a colon and all ones.
        header_bytes = {dlpd_pkg::CHAR_SPACE, dlpd_pkg::CHAR_TAB, dlpd_pkg::CHAR_PLUS};
        add_decimal(3);
        push_frame_head();
        push_byte(8'hFF);
        push_byte(dlpd_pkg::CHAR_COLON);
        push_byte(8'h80);

        // A NUL ends the number, so the digit behind it is ignored.
        header_bytes = {CHAR_LF};
        add_decimal(2);
        header_bytes.push_back(CHAR_NUL);
        add_decimal(7);
        push_frame_head();
        push_byte(8'h55);
        push_byte(8'hAA);

        // Leading zeros, then text and a digit after the number.
        header_bytes = {CHAR_VT, CHAR_FF, dlpd_pkg::CHAR_CR,
                        dlpd_pkg::CHAR_ZERO, dlpd_pkg::CHAR_ZERO};
        add_decimal(1);
        header_bytes.push_back(8'h78);
        header_bytes.push_back(dlpd_pkg::CHAR_NINE);
        push_frame_head();
        push_byte(8'h01);

        phase_limits = '{1, 24'hFFFFFF, $urandom_range(2, 40),
                         $urandom_range(41, 24'hFFFFFE), dlpd_pkg::MAX_LEN_RESET};
        for (p = 0; p < 5; p++)
        begin
            settle();
            if (p == 2)
                apb_transfer(1'b1, ADDR_UNMAPPED, $urandom);
            set_limit(dlpd_pkg::MAX_LEN_BITS'(phase_limits[p]));
            // Stall the output long enough for the block to push back on input.
            if (p == 1 || p == 3)
                hold_requests <= hold_requests + 1;
            target = bytes_sent + 145;
            while (bytes_sent < target)
                send_message();
        end

        // The stream ends with one bad header; everything after it is dropped.
        settle();
        fault = header_fault_t'($urandom_range(0, FAULT_LIMIT_ZERO));
        if ($urandom_range(0, 1) == 0)
            header_bytes.push_back(blank_byte());
        case (fault)
            FAULT_COLON_FIRST: ;
            FAULT_SIGN_ONLY:
                header_bytes.push_back($urandom_range(0, 1) ? dlpd_pkg::CHAR_PLUS
                                                            : dlpd_pkg::CHAR_MINUS);
            FAULT_JUNK_FIRST:
            begin
                header_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
                add_decimal($urandom_range(1, 9));
            end
            FAULT_NEGATIVE:
            begin
                header_bytes.push_back(dlpd_pkg::CHAR_MINUS);
                add_decimal($urandom_range(1, 500));
            end
            FAULT_MINUS_ZERO:
                header_bytes = {header_bytes, dlpd_pkg::CHAR_MINUS, dlpd_pkg::CHAR_ZERO};
            FAULT_ZERO_LENGTH:
                repeat ($urandom_range(1, 3))
                    header_bytes.push_back(dlpd_pkg::CHAR_ZERO);
            FAULT_OVERFLOW:
                add_decimal($urandom_range(32'hFFFFFFFF, 32'd16777216));
            FAULT_ABOVE_LIMIT:
            begin
                lim = dlpd_pkg::MAX_LEN_BITS'($urandom_range(1, 5000));
                set_limit(lim);
                add_decimal(lim + $urandom_range(1, 1000));
            end
            default:
            begin
                set_limit('0);
                add_decimal($urandom_range(1, 99));
            end
        endcase
        push_frame_head();
        repeat (DROP_COUNT)
            push_byte(8'($urandom));
        settle();

        $display("Covered %0d frames in %0d stream bytes under %0d length limits,",
                 frames_sent, bytes_sent, settings_used);
        $display("%0d results checked; the stream closed by a %s header error, then %0d %s",
                 results_checked, fault.name(), DROP_COUNT, "bytes that must be dropped.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timeout at %0t with %0d results still outstanding", $time, pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/dlpd_pkg.sv
src/dlpd_front.sv
src/dlpd_queue.sv
src/dlpd_back.sv
src/decimal_length_prefix_deframer.sv
src/dlpd_checker.sv
tb/dlpd_stream_checker.sv
tb/tb_decimal_length_prefix_deframer.sv
